// File: sv/frbq_pkg.sv
// Shared types, constants and pointer helpers for the framed byte ring queue.
// Used by frbq_ctrl and framed_byte_ring_queue_core. Depends on nothing.

package frbq_pkg;

  // Ring size and derived widths
  localparam int BUF_BYTES = 4096;
  localparam int PTR_W     = $clog2(BUF_BYTES);
  localparam int CNT_W     = PTR_W + 1;
  localparam int LEN_W     = 12;
  localparam int CMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int VALUE_W   = 64;

  typedef logic [PTR_W-1:0] ptr_t;

  // Request operations
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ACCEPTED  = 3'd0,
    KIND_REJECTED  = 3'd1,
    KIND_EMPTY     = 3'd2,
    KIND_ADDR_LEN  = 3'd3,
    KIND_ADDR_BYTE = 3'd4,
    KIND_CONN_ID   = 3'd5,
    KIND_PAY_LEN   = 3'd6,
    KIND_PAY_BYTE  = 3'd7
  } kind_t;

  // Record field sequence on the pop side
  typedef enum logic [2:0] {
    PH_ADDR_LEN   = 3'd0,
    PH_ADDR_BYTES = 3'd1,
    PH_CONN_ID    = 3'd2,
    PH_PAY_LEN    = 3'd3,
    PH_PAY_BYTES  = 3'd4
  } phase_t;

  // One result from the sequencer to the output register
  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } result_t;

  // Advance a ring pointer with wrap
  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(BUF_BYTES - 1)) begin
      r = '0;
    end else begin
      r = ptr_t'(p + ptr_t'(1));
    end
    return r;
  endfunction

  // Bytes stored between read and write pointers
  function automatic ptr_t fill_level(input ptr_t wp, input ptr_t rp);
    logic [CNT_W-1:0] s;
    ptr_t             r;
    s = {1'b0, wp} + CNT_W'(BUF_BYTES) - {1'b0, rp};
    if (wp >= rp) begin
      r = ptr_t'(wp - rp);
    end else begin
      r = s[PTR_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/frbq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; sized by its parameters.

module frbq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/frbq_ctrl.sv
// Push admission and record-field pop sequencer for the framed byte ring queue.
// Depends on frbq_pkg; drives the ring RAM ports and hands results to the top level.

module frbq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          op,
  input  logic [7:0]                    data_byte,
  input  logic [frbq_pkg::LEN_W-1:0]    msg_length,
  input  logic                          first_byte,
  output logic                          busy,
  output frbq_pkg::result_t             res,
  output logic                          ram_wr_en,
  output frbq_pkg::ptr_t                ram_wr_addr,
  output logic [7:0]                    ram_wr_data,
  output logic                          ram_rd_en,
  output frbq_pkg::ptr_t                ram_rd_addr,
  input  logic [7:0]                    ram_rd_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_READ = 3'b100
  } state_t;

  // Control state
  state_t                         state, state_next;
  frbq_pkg::ptr_t                 wp, wp_next;
  frbq_pkg::ptr_t                 rp, rp_next;
  logic                           macc, macc_next;
  frbq_pkg::phase_t               phase, phase_next;
  logic [15:0]                    rem, rem_next;

  // Latched request and read sequencing
  logic                           op_q;
  logic [7:0]                     db_q;
  logic [frbq_pkg::LEN_W-1:0]     len_q;
  logic                           fb_q;
  frbq_pkg::ptr_t                 cursor, cursor_next;
  logic [3:0]                     iss, iss_next;
  logic [2:0]                     got, got_next;
  logic                           pend, pend_next;
  logic [3:0]                     need, need_next;
  logic [frbq_pkg::VALUE_W-1:0]   acc, acc_next;

  // Derived values
  frbq_pkg::ptr_t                 used;
  logic [frbq_pkg::CNT_W-1:0]     free;
  logic                           fits;
  logic                           acc_flag;
  frbq_pkg::phase_t               phase_eff;
  logic [3:0]                     need_eff;
  logic [frbq_pkg::VALUE_W-1:0]   merged;
  logic [15:0]                    len16;
  logic [15:0]                    rem_dec;

  assign busy = (state != ST_IDLE);

  // Fill level, admission test and field width
  always_comb begin
    used     = frbq_pkg::fill_level(wp, rp);
    free     = frbq_pkg::CNT_W'(frbq_pkg::BUF_BYTES) - {1'b0, used};
    fits     = frbq_pkg::CMP_W'(free) > frbq_pkg::CMP_W'(len_q);
    acc_flag = fb_q ? fits : macc;
    unique case (phase)
      frbq_pkg::PH_ADDR_BYTES,
      frbq_pkg::PH_CONN_ID,
      frbq_pkg::PH_PAY_LEN,
      frbq_pkg::PH_PAY_BYTES: phase_eff = phase;
      default:                phase_eff = frbq_pkg::PH_ADDR_LEN;
    endcase
    unique case (phase_eff)
      frbq_pkg::PH_CONN_ID:    need_eff = 4'd8;
      frbq_pkg::PH_ADDR_BYTES,
      frbq_pkg::PH_PAY_BYTES:  need_eff = 4'd1;
      default:                 need_eff = 4'd2;
    endcase
    merged                   = acc;
    merged[{got, 3'b000} +: 8] = ram_rd_data;
    len16                    = merged[15:0];
    rem_dec                  = (rem != 16'd0) ? 16'(rem - 16'd1) : 16'd0;
  end

  // Sequencer
  always_comb begin
    state_next  = state;
    wp_next     = wp;
    rp_next     = rp;
    macc_next   = macc;
    phase_next  = phase;
    rem_next    = rem;
    cursor_next = cursor;
    iss_next    = iss;
    got_next    = got;
    pend_next   = 1'b0;
    need_next   = need;
    acc_next    = acc;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;
    res         = '{valid: 1'b0, kind: frbq_pkg::KIND_ACCEPTED, value: '0, last: 1'b0};

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (op_q == frbq_pkg::OP_PUSH) begin
          // Admit or drop one message byte
          res.valid  = 1'b1;
          macc_next  = acc_flag;
          state_next = ST_IDLE;
          if (!acc_flag) begin
            res.kind = frbq_pkg::KIND_REJECTED;
          end else if (used >= frbq_pkg::ptr_t'(frbq_pkg::BUF_BYTES - 1)) begin
            macc_next = 1'b0;
            res.kind  = frbq_pkg::KIND_REJECTED;
          end else begin
            ram_wr_en = 1'b1;
            wp_next   = frbq_pkg::ptr_inc(wp);
            res.kind  = frbq_pkg::KIND_ACCEPTED;
          end
        end else begin
          // Check stored bytes against the field width, then start reads
          phase_next = phase_eff;
          need_next  = need_eff;
          if (used < frbq_pkg::ptr_t'(need_eff)) begin
            res.valid  = 1'b1;
            res.kind   = frbq_pkg::KIND_EMPTY;
            state_next = ST_IDLE;
          end else begin
            state_next  = ST_READ;
            cursor_next = rp;
            iss_next    = 4'd0;
            got_next    = 3'd0;
            acc_next    = '0;
          end
        end
      end

      ST_READ: begin
        // Issue one byte read per cycle
        ram_rd_en = (iss < need);
        pend_next = ram_rd_en;
        if (ram_rd_en) begin
          cursor_next = frbq_pkg::ptr_inc(cursor);
          iss_next    = 4'(iss + 4'd1);
        end
        // Collect returned bytes, little-endian
        if (pend) begin
          acc_next = merged;
          got_next = 3'(got + 3'd1);
          if (4'({1'b0, got} + 4'd1) == need) begin
            res.valid  = 1'b1;
            res.value  = merged;
            rp_next    = cursor;
            state_next = ST_IDLE;
            unique case (phase)
              frbq_pkg::PH_ADDR_LEN: begin
                res.kind = frbq_pkg::KIND_ADDR_LEN;
                if (len16 == 16'd0) begin
                  phase_next = frbq_pkg::PH_CONN_ID;
                end else begin
                  rem_next   = len16;
                  phase_next = frbq_pkg::PH_ADDR_BYTES;
                end
              end
              frbq_pkg::PH_ADDR_BYTES: begin
                res.kind = frbq_pkg::KIND_ADDR_BYTE;
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                  phase_next = frbq_pkg::PH_CONN_ID;
                end
              end
              frbq_pkg::PH_CONN_ID: begin
                res.kind   = frbq_pkg::KIND_CONN_ID;
                phase_next = frbq_pkg::PH_PAY_LEN;
              end
              frbq_pkg::PH_PAY_LEN: begin
                res.kind = frbq_pkg::KIND_PAY_LEN;
                if (len16 == 16'd0) begin
                  res.last   = 1'b1;
                  phase_next = frbq_pkg::PH_ADDR_LEN;
                end else begin
                  rem_next   = len16;
                  phase_next = frbq_pkg::PH_PAY_BYTES;
                end
              end
              frbq_pkg::PH_PAY_BYTES: begin
                res.kind = frbq_pkg::KIND_PAY_BYTE;
                rem_next = rem_dec;
                if (rem_dec == 16'd0) begin
                  res.last   = 1'b1;
                  phase_next = frbq_pkg::PH_ADDR_LEN;
                end
              end
              default: begin
                phase_next = frbq_pkg::PH_ADDR_LEN;
              end
            endcase
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign ram_wr_addr = wp;
  assign ram_wr_data = db_q;
  assign ram_rd_addr = cursor;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp    <= '0;
      rp    <= '0;
      macc  <= 1'b0;
      phase <= frbq_pkg::PH_ADDR_LEN;
      rem   <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      rp    <= rp_next;
      macc  <= macc_next;
      phase <= phase_next;
      rem   <= rem_next;
      pend  <= pend_next;
    end
  end

  // Request latch and read bookkeeping
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start) begin
      op_q  <= op;
      db_q  <= data_byte;
      len_q <= msg_length;
      fb_q  <= first_byte;
    end
    cursor <= cursor_next;
    iss    <= iss_next;
    got    <= got_next;
    need   <= need_next;
    acc    <= acc_next;
  end

endmodule

// File: sv/framed_byte_ring_queue_core.sv
// Top level of the framed byte ring queue: ring RAM, sequencer and result register.
// Depends on frbq_pkg, frbq_ram and frbq_ctrl.
//
//   channel   ports                                        handshake
//   request   op, data_byte, msg_length, first_byte        start high while busy low
//   result    kind, value, last_of_record                  done high for one cycle
//
// A push, or a pop that finds too few bytes, is handled in the EXEC state alone.
// A pop of an n-byte field (n = 1, 2 or 8) goes on to the READ state: one byte read
// per cycle through the single RAM read port, with registered read data.
// done rises in the cycle after the work ends; the next request may be taken then.
// rst (synchronous) empties the ring and returns to record start; RAM is not cleared.
// The receiver cannot stall: each result is shown once, on the done cycle.

module framed_byte_ring_queue_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op,
  input  logic [7:0]                  data_byte,
  input  logic [frbq_pkg::LEN_W-1:0]  msg_length,
  input  logic                        first_byte,
  output logic                        done,
  output logic [2:0]                  kind,
  output logic signed [63:0]          value,
  output logic                        last_of_record
);

  frbq_pkg::result_t res;
  logic              ram_wr_en;
  frbq_pkg::ptr_t    ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic              ram_rd_en;
  frbq_pkg::ptr_t    ram_rd_addr;
  logic [7:0]        ram_rd_data;

  frbq_ram #(
    .DATA_W (8),
    .DEPTH  (frbq_pkg::BUF_BYTES),
    .ADDR_W (frbq_pkg::PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  frbq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .op          (op),
    .data_byte   (data_byte),
    .msg_length  (msg_length),
    .first_byte  (first_byte),
    .busy        (busy),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  // Strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  // Hold the result payload for its done cycle
  always_ff @(posedge clk) begin
    if (res.valid) begin
      kind           <= res.kind;
      value          <= res.value;
      last_of_record <= res.last;
    end
  end

endmodule

// File: test/framed_byte_ring_queue_core_tb.sv
// Self-checking testbench for framed_byte_ring_queue_core: directed and random requests.
// Depends on frbq_pkg and framed_byte_ring_queue_core; the expected fields come from a local model.
`timescale 1ns / 1ps

module framed_byte_ring_queue_core_tb;

  localparam int LEN_MAX = (1 << frbq_pkg::LEN_W) - 1;

  typedef struct {
    logic                       drain_wait;
    logic                       op;
    logic [7:0]                 db;
    logic [frbq_pkg::LEN_W-1:0] len;
    logic                       fb;
  } req_t;

  typedef struct {
    frbq_pkg::kind_t kind;
    logic [63:0]     value;
    logic            last;
  } field_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic op = frbq_pkg::OP_PUSH;
  logic [7:0] data_byte = '0;
  logic [frbq_pkg::LEN_W-1:0] msg_length = '0;
  logic first_byte = 1'b0;
  logic busy;
  logic done;
  logic [2:0] kind;
  logic signed [63:0] value;
  logic last_of_record;

  req_t       request_q[$];
  field_rec_t pending_results[$];
  logic [7:0] rec_bytes[$];
  logic       req_taken = 1'b0;
  int         err_count = 0;
  int         burst_left = 1;
  int         gap_left = 0;
  req_t       cur_req;
  field_rec_t got_exp;
  field_rec_t new_exp;

  // Local copy of the queue state
  logic [7:0]        ring_mem [frbq_pkg::BUF_BYTES];
  int                wr_ptr = 0;
  int                rd_ptr = 0;
  logic              msg_open = 1'b0;
  frbq_pkg::phase_t  field_phase = frbq_pkg::PH_ADDR_LEN;
  int                left_count = 0;

  framed_byte_ring_queue_core u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .data_byte      (data_byte),
    .msg_length     (msg_length),
    .first_byte     (first_byte),
    .done           (done),
    .kind           (kind),
    .value          (value),
    .last_of_record (last_of_record)
  );

  always #2 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    err_count++;
    $display("%0t ns: MISMATCH %s", $time, msg);
  endtask

  function automatic logic [frbq_pkg::LEN_W-1:0] rand_len();
    return frbq_pkg::LEN_W'($urandom);
  endfunction

  function automatic logic [63:0] peek_bytes(input int n);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < n; k++) begin
      v[8*k +: 8] = ring_mem[(rd_ptr + k) % frbq_pkg::BUF_BYTES];
    end
    return v;
  endfunction

  // Advance the local queue state by one request and give the field it answers
  task automatic predict_field(input logic op_i, input logic [7:0] db,
                               input logic [frbq_pkg::LEN_W-1:0] len, input logic fb,
                               output field_rec_t r);
    int          used;
    logic [63:0] v;
    used = (wr_ptr + frbq_pkg::BUF_BYTES - rd_ptr) % frbq_pkg::BUF_BYTES;
    r.kind  = frbq_pkg::KIND_ACCEPTED;
    r.value = '0;
    r.last  = 1'b0;
    if (op_i == frbq_pkg::OP_PUSH) begin
      if (fb) begin
        msg_open = (frbq_pkg::BUF_BYTES - used) > int'(len);
      end
      if (!msg_open) begin
        r.kind = frbq_pkg::KIND_REJECTED;
      end else if (used >= frbq_pkg::BUF_BYTES - 1) begin
        // ring full: drop this byte and the rest of the message
        msg_open = 1'b0;
        r.kind = frbq_pkg::KIND_REJECTED;
      end else begin
        ring_mem[wr_ptr] = db;
        wr_ptr = (wr_ptr + 1) % frbq_pkg::BUF_BYTES;
      end
    end else begin
      case (field_phase)
        frbq_pkg::PH_ADDR_BYTES: begin
          if (used < 1) begin
            r.kind = frbq_pkg::KIND_EMPTY;
          end else begin
            r.kind = frbq_pkg::KIND_ADDR_BYTE;
            r.value = peek_bytes(1);
            rd_ptr = (rd_ptr + 1) % frbq_pkg::BUF_BYTES;
            if (left_count > 0) left_count--;
            if (left_count == 0) field_phase = frbq_pkg::PH_CONN_ID;
          end
        end
        frbq_pkg::PH_CONN_ID: begin
          if (used < 8) begin
            r.kind = frbq_pkg::KIND_EMPTY;
          end else begin
            r.kind = frbq_pkg::KIND_CONN_ID;
            r.value = peek_bytes(8);
            rd_ptr = (rd_ptr + 8) % frbq_pkg::BUF_BYTES;
            field_phase = frbq_pkg::PH_PAY_LEN;
          end
        end
        frbq_pkg::PH_PAY_LEN: begin
          if (used < 2) begin
            r.kind = frbq_pkg::KIND_EMPTY;
          end else begin
            r.kind = frbq_pkg::KIND_PAY_LEN;
            v = peek_bytes(2);
            r.value = v;
            rd_ptr = (rd_ptr + 2) % frbq_pkg::BUF_BYTES;
            if (v == 0) begin
              r.last = 1'b1;
              field_phase = frbq_pkg::PH_ADDR_LEN;
            end else begin
              left_count = int'(v[15:0]);
              field_phase = frbq_pkg::PH_PAY_BYTES;
            end
          end
        end
        frbq_pkg::PH_PAY_BYTES: begin
          if (used < 1) begin
            r.kind = frbq_pkg::KIND_EMPTY;
          end else begin
            r.kind = frbq_pkg::KIND_PAY_BYTE;
            r.value = peek_bytes(1);
            rd_ptr = (rd_ptr + 1) % frbq_pkg::BUF_BYTES;
            if (left_count > 0) left_count--;
            if (left_count == 0) begin
              r.last = 1'b1;
              field_phase = frbq_pkg::PH_ADDR_LEN;
            end
          end
        end
        default: begin
          field_phase = frbq_pkg::PH_ADDR_LEN;
          if (used < 2) begin
            r.kind = frbq_pkg::KIND_EMPTY;
          end else begin
            r.kind = frbq_pkg::KIND_ADDR_LEN;
            v = peek_bytes(2);
            r.value = v;
            rd_ptr = (rd_ptr + 2) % frbq_pkg::BUF_BYTES;
            if (v == 0) begin
              field_phase = frbq_pkg::PH_CONN_ID;
            end else begin
              left_count = int'(v[15:0]);
              field_phase = frbq_pkg::PH_ADDR_BYTES;
            end
          end
        end
      endcase
    end
  endtask

  // Request queue builders
  task automatic add_push(input logic [7:0] b, input logic [frbq_pkg::LEN_W-1:0] len,
                          input logic fb);
    req_t rq;
    rq.drain_wait = 1'b0;
    rq.op = frbq_pkg::OP_PUSH;
    rq.db = b;
    rq.len = len;
    rq.fb = fb;
    request_q.push_back(rq);
  endtask

  task automatic add_pop();
    req_t rq;
    rq.drain_wait = 1'b0;
    rq.op = frbq_pkg::OP_POP;
    rq.db = 8'($urandom);
    rq.len = rand_len();
    rq.fb = 1'($urandom);
    request_q.push_back(rq);
  endtask

  task automatic add_pause();
    req_t rq;
    rq.drain_wait = 1'b1;
    rq.op = frbq_pkg::OP_POP;
    rq.db = '0;
    rq.len = '0;
    rq.fb = 1'b0;
    request_q.push_back(rq);
  endtask

  // Build one record: address length, address, connection id, payload length, payload
  task automatic make_record(input int a, input int p);
    int pat;
    rec_bytes.delete();
    rec_bytes.push_back(a[7:0]);
    rec_bytes.push_back(a[15:8]);
    repeat (a) rec_bytes.push_back(8'($urandom));
    pat = $urandom_range(0, 7);
    for (int k = 0; k < 8; k++) begin
      if (pat == 0) rec_bytes.push_back(8'hFF);
      else if (pat == 1) rec_bytes.push_back(8'h00);
      else if (pat == 2) rec_bytes.push_back((k == 7) ? 8'h7F : 8'hFF);
      else rec_bytes.push_back(8'($urandom));
    end
    rec_bytes.push_back(p[7:0]);
    rec_bytes.push_back(p[15:8]);
    repeat (p) rec_bytes.push_back(8'($urandom));
  endtask

  // Put idle noise on the request fields
  task automatic drive_idle();
    start <= 1'b0;
    op <= 1'($urandom);
    data_byte <= 8'($urandom);
    msg_length <= rand_len();
    first_byte <= 1'($urandom);
  endtask

  // Driver: hold a request until taken, then send in bursts with gaps
  always @(negedge clk) begin
    if (rst) begin
      drive_idle();
    end else if (start && !req_taken) begin
      // hold the request
    end else if (gap_left > 0) begin
      gap_left--;
      drive_idle();
    end else if (request_q.size() == 0) begin
      drive_idle();
    end else if (request_q[0].drain_wait) begin
      drive_idle();
      if (pending_results.size() == 0) void'(request_q.pop_front());
    end else begin
      cur_req = request_q.pop_front();
      start <= 1'b1;
      op <= cur_req.op;
      data_byte <= cur_req.db;
      msg_length <= cur_req.len;
      first_byte <= cur_req.fb;
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 12);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
    end
  end

  // Monitor: check each result, then predict any request taken at this edge
  always @(posedge clk) begin
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result kind %0d with nothing expected", kind));
        end else begin
          got_exp = pending_results.pop_front();
          if (kind !== got_exp.kind)
            flag_mismatch($sformatf("kind got %0d exp %0d", kind, got_exp.kind));
          if (value !== got_exp.value)
            flag_mismatch($sformatf("value got %h exp %h (kind %0d)",
                                    value, got_exp.value, got_exp.kind));
          if (last_of_record !== got_exp.last)
            flag_mismatch($sformatf("last_of_record got %b exp %b (kind %0d)",
                                    last_of_record, got_exp.last, got_exp.kind));
        end
      end
      req_taken = start && !busy;
      if (req_taken) begin
        predict_field(op, data_byte, msg_length, first_byte, new_exp);
        pending_results.push_back(new_exp);
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [7:0] m1 [14];
    int nrec, a, p, n_fields, claim, tail, rand_base;

    // pop from an empty ring, then a stray byte with no open message
    add_pop();
    add_push(8'hAB, rand_len(), 1'b0);

    // one record: address length 1, minimum connection id, one payload byte
    m1 = '{8'h01, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
           8'h00, 8'h00, 8'h80, 8'h01, 8'h00, 8'hFF};
    add_push(m1[0], frbq_pkg::LEN_W'(LEN_MAX), 1'b1);
    for (int k = 1; k < 5; k++) add_push(m1[k], rand_len(), 1'b0);
    // address length, address byte, then the connection id runs out of data
    repeat (3) add_pop();
    for (int k = 5; k < 14; k++) add_push(m1[k], rand_len(), 1'b0);
    // too long for the free space: the message and its next byte are dropped
    add_push(8'h5A, frbq_pkg::LEN_W'(LEN_MAX), 1'b1);
    add_push(8'hA5, rand_len(), 1'b0);
    repeat (4) add_pop();
    add_pause();

    // random rounds of well-formed records with random claims and extra pops
    rand_base = request_q.size();
    while (request_q.size() - rand_base < 550) begin
      nrec = $urandom_range(1, 4);
      n_fields = 0;
      for (int r = 0; r < nrec; r++) begin
        a = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 48) : $urandom_range(0, 4);
        p = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 8);
        make_record(a, p);
        n_fields += 3 + a + p;
        case ($urandom_range(0, 5))
          0, 1: claim = rec_bytes.size();
          2: claim = 0;
          3: claim = LEN_MAX;
          4: claim = $urandom_range(0, LEN_MAX);
          default: claim = $urandom_range(LEN_MAX - 31, LEN_MAX);
        endcase
        foreach (rec_bytes[k]) begin
          if ($urandom_range(0, 5) == 0) add_pop();
          if (k == 0) add_push(rec_bytes[k], frbq_pkg::LEN_W'(claim), 1'b1);
          else add_push(rec_bytes[k], rand_len(), 1'b0);
        end
      end
      // drain the round, or leave some fields behind now and then
      tail = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_fields)
                                         : n_fields + $urandom_range(1, 2);
      repeat (tail) add_pop();
      if ($urandom_range(0, 5) == 0) add_pause();
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (request_q.size() != 0 || start) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    if (err_count == 0) begin
      $display("framed_byte_ring_queue_core test passed");
    end else begin
      $display("framed_byte_ring_queue_core test failed");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #2000000;
    $display("framed_byte_ring_queue_core test failed");
    $finish;
  end

endmodule

// File: files.f
sv/frbq_pkg.sv
sv/frbq_ram.sv
sv/frbq_ctrl.sv
sv/framed_byte_ring_queue_core.sv
test/framed_byte_ring_queue_core_tb.sv
